>>> rtl/core/lfcs_pkg.sv
// ----------------------------------------------------------------------------
// lfcs_pkg
// Shared types and constants for the line-fit compass search core.
// ----------------------------------------------------------------------------
package lfcs_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_ITER  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;
  localparam logic        [31:0] STEP_INIT = 32'h000A_0000;

  // Queue entry between front and back.
  typedef struct packed {
    op_t         op;
    logic [15:0] x;
    logic [15:0] y;
  } cmd_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_PREP,
    BS_SWEEP,
    BS_DECIDE,
    BS_OUT
  } bstate_t;

  // Saturating add of a 32-bit signed value and a 33-bit signed delta.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [32:0] b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    if (s > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (s < -34'sh0_8000_0000) return 32'sh8000_0000;
    else return s[31:0];
  endfunction

endpackage

>>> rtl/core/lfcs_ram.sv
// ----------------------------------------------------------------------------
// lfcs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lfcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/lfcs_front.sv
// ----------------------------------------------------------------------------
// lfcs_front
// Accepts transactions and holds them in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module lfcs_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  output logic                         ready,
  input  logic [1:0]                   opcode,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  output logic                         q_valid,
  input  logic                         q_pop,
  output lfcs_pkg::cmd_t               q_data
);
  lfcs_pkg::cmd_t buffer [2];
  logic           wptr, rptr;
  logic [1:0]     fill;
  logic           push;
  lfcs_pkg::cmd_t cmd;

  assign ready   = (fill != 2'd2);
  assign push    = valid && ready;
  assign q_valid = (fill != 2'd0);
  assign q_data  = buffer[rptr];

  always_comb begin
    cmd.op = lfcs_pkg::op_t'(opcode);
    cmd.x  = 16'(point_x);
    cmd.y  = 16'(point_y);
  end

  always_ff @(posedge clk) begin
    if (push) buffer[wptr] <= cmd;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end
endmodule

>>> rtl/core/lfcs_back.sv
// ----------------------------------------------------------------------------
// lfcs_back
// Executes queued commands: point store upkeep and the compass search step.
// ----------------------------------------------------------------------------
module lfcs_back #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  lfcs_pkg::cmd_t      q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  fit_slope,
  output logic signed [31:0]  fit_intercept,
  output logic                store_full
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  lfcs_pkg::bstate_t state, state_next;

  logic [CW-1:0]       count, last_count, idx;
  logic signed [31:0]  slope, icpt, t_slope, t_icpt;
  logic [31:0]         sstep, istep;
  logic [2:0]          trial;      // 0 base, 1 s+, 2 s-, 3 i+, 4 i-
  logic [63:0]         base, acc;
  logic                full_flag;
  logic                rd_valid;   // read data of previous cycle is a point
  logic                mul_valid;
  logic signed [47:0]  prod;
  logic signed [COORD_BITS-1:0] rx, ry;
  logic signed [COORD_BITS-1:0] ry_d;
  logic [2*COORD_BITS-1:0] rdata;
  logic signed [49:0]  diff;
  logic [49:0]         adiff;
  logic                we;
  logic [AW-1:0]       ridx;

  assign we    = (state == lfcs_pkg::BS_IDLE) && q_valid &&
                 q_data.op == lfcs_pkg::OP_ADD && count < CW'(MAX_POINTS);
  assign ridx  = idx[AW-1:0];

  lfcs_ram #(.WIDTH(2*COORD_BITS), .DEPTH(MAX_POINTS)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(count[AW-1:0]),
    .wdata({q_data.x[COORD_BITS-1:0], q_data.y[COORD_BITS-1:0]}),
    .raddr(ridx),
    .rdata(rdata)
  );

  assign rx = rdata[2*COORD_BITS-1:COORD_BITS];
  assign ry = rdata[COORD_BITS-1:0];

  always_comb begin
    diff  = (50'(ry_d) <<< 16) - 50'(prod) - 50'(t_icpt);
    adiff = diff[49] ? 50'(-diff) : 50'(diff);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lfcs_pkg::BS_IDLE:
        if (q_valid) state_next = (q_data.op == lfcs_pkg::OP_ITER) ?
                                  lfcs_pkg::BS_PREP : lfcs_pkg::BS_OUT;
      lfcs_pkg::BS_PREP:   state_next = lfcs_pkg::BS_SWEEP;
      lfcs_pkg::BS_SWEEP:
        if (idx >= count && !rd_valid && !mul_valid)
          state_next = lfcs_pkg::BS_DECIDE;
      lfcs_pkg::BS_DECIDE: state_next = (trial == 3'd4 ||
                                         (trial == 3'd3 && acc < base)) ?
                                        lfcs_pkg::BS_OUT : lfcs_pkg::BS_SWEEP;
      lfcs_pkg::BS_OUT:    if (out_ready) state_next = lfcs_pkg::BS_IDLE;
      default:             state_next = lfcs_pkg::BS_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    q_pop         = (state == lfcs_pkg::BS_IDLE) && q_valid;
    out_valid     = (state == lfcs_pkg::BS_OUT);
    fit_slope     = slope;
    fit_intercept = icpt;
    store_full    = full_flag;
  end

  always_ff @(posedge clk) begin
    ry_d <= ry;
    prod <= 48'(rx) * 48'(t_slope);
    if (rst) begin
      state      <= lfcs_pkg::BS_IDLE;
      count      <= '0;
      last_count <= '0;
      slope      <= lfcs_pkg::Q_ONE;
      icpt       <= '0;
      sstep      <= lfcs_pkg::STEP_INIT;
      istep      <= lfcs_pkg::STEP_INIT;
      full_flag  <= 1'b0;
      rd_valid   <= 1'b0;
      mul_valid  <= 1'b0;
      idx        <= '0;
      trial      <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        lfcs_pkg::BS_IDLE: if (q_valid) begin
          full_flag <= 1'b0;
          unique case (q_data.op)
            lfcs_pkg::OP_ADD:
              if (count < CW'(MAX_POINTS)) count <= count + 1'b1;
              else full_flag <= 1'b1;
            lfcs_pkg::OP_CLEAR: count <= '0;
            lfcs_pkg::OP_ITER: if (count != last_count) begin
              last_count <= count;
              sstep <= lfcs_pkg::STEP_INIT;
              istep <= lfcs_pkg::STEP_INIT;
              slope <= lfcs_pkg::Q_ONE;
              icpt  <= '0;
            end
            lfcs_pkg::OP_NONE: ;
            default: ;
          endcase
        end
        lfcs_pkg::BS_PREP: begin
          trial   <= 3'd0;
          t_slope <= slope;
          t_icpt  <= icpt;
          idx     <= '0;
          acc     <= '0;
        end
        lfcs_pkg::BS_SWEEP: begin
          rd_valid  <= idx < count;
          mul_valid <= rd_valid;
          if (idx < count) idx <= idx + 1'b1;
          if (mul_valid) acc <= acc + 64'(adiff);
        end
        lfcs_pkg::BS_DECIDE: begin
          idx <= '0;
          acc <= '0;
          unique case (trial)
            3'd0: begin
              base    <= acc;
              trial   <= 3'd1;
              t_slope <= lfcs_pkg::sat_add(slope, 33'($signed({1'b0, sstep})));
            end
            3'd1: if (acc < base) begin
              slope   <= t_slope;
              trial   <= 3'd3;
              t_icpt  <= lfcs_pkg::sat_add(icpt, 33'($signed({1'b0, istep})));
            end else begin
              trial   <= 3'd2;
              t_slope <= lfcs_pkg::sat_add(slope, -33'($signed({1'b0, sstep})));
            end
            3'd2: begin
              if (acc < base) slope <= t_slope;
              else begin
                slope   <= slope;
                sstep   <= 32'((35'(sstep) * 35'd3) >> 2);
                t_slope <= slope;
              end
              trial  <= 3'd3;
              t_icpt <= lfcs_pkg::sat_add(icpt, 33'($signed({1'b0, istep})));
            end
            3'd3: if (acc < base) begin
              icpt  <= t_icpt;
              trial <= 3'd4;
            end else begin
              trial  <= 3'd4;
              t_icpt <= lfcs_pkg::sat_add(icpt, -33'($signed({1'b0, istep})));
            end
            3'd4: begin
              if (acc < base) icpt <= t_icpt;
              else istep <= 32'((35'(istep) * 35'd3) >> 2);
            end
            default: ;
          endcase
        end
        lfcs_pkg::BS_OUT: ;
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/core/l1_line_fit_compass_search_core.sv
// ----------------------------------------------------------------------------
// l1_line_fit_compass_search_core
// Least-absolute-deviation line fit by compass search over a point store.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): opcode, point_x, point_y. Add appends a point,
// clear empties the store, iterate runs one search step on slope and
// intercept. Output channel (out_valid/out_ready): one transaction per input,
// carrying the line after the item and the store_full flag.
// A two-entry queue parts the accepting front from the executing back, so
// the front keeps taking transactions while the back works or stalls.
// Add, clear and the unused code go straight from the idle state to the
// output state. An iterate sweeps the point store once for the base sum
// and up to four more times for trials, each sweep reading the N stored
// points through the single RAM read port and ending in a decide state.
// The back handles one transaction at a time.
// Reset: synchronous; empties the store and sets slope 1.0, intercept 0,
// both steps 10.0. Store content is not cleared; only written entries
// are read. A stalled receiver holds the back, the queue fills and in_ready
// then drops.
// ----------------------------------------------------------------------------
module l1_line_fit_compass_search_core #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   opcode,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           fit_slope,
  output logic signed [31:0]           fit_intercept,
  output logic                         store_full
);
  logic           q_valid, q_pop;
  lfcs_pkg::cmd_t q_data;

  // Accept and hold incoming transactions.
  lfcs_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst),
    .valid(in_valid), .ready(in_ready),
    .opcode(opcode), .point_x(point_x), .point_y(point_y),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  // Execute each command and present its result.
  lfcs_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .fit_slope(fit_slope), .fit_intercept(fit_intercept),
    .store_full(store_full)
  );
endmodule
